// ----- hw/rtl/afr_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, types and the CRC byte update for the addressed frame receiver.
package afr_pkg;

	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned HDR_LEN   = 6;
	localparam int unsigned SUM_LEN   = 5;
	localparam int unsigned CRC_BITS  = 16;
	localparam int unsigned ADDR_BITS = 16;
	localparam int unsigned APB_DATA_BITS = 32;
	localparam int unsigned APB_ADDR_BITS = 2;

	localparam logic [CRC_BITS-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_BITS-1:0] CRC_POLY = 16'hA001;

	// Register byte addresses.
	localparam logic [APB_ADDR_BITS-1:0] REG_LOCAL_ADDRESS = 2'd0;

	typedef logic [BYTE_BITS-1:0] byte_t;

	typedef struct packed {
		byte_t payload_byte;
		logic  is_payload;
		logic  frame_last;
		logic  crc_good;
		byte_t frame_length;
	} result_t;

	// Reflected CRC-16 update over one byte, one bit per step.
	function automatic logic [CRC_BITS-1:0] crc_byte(input logic [CRC_BITS-1:0] crc,
		input byte_t b);
		logic [CRC_BITS-1:0] c;
		c = crc ^ {{(CRC_BITS-BYTE_BITS){1'b0}}, b};
		for (int i = 0; i < BYTE_BITS; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- hw/rtl/afr_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and frame results.
interface afr_rx_if;
	import afr_pkg::*;
	logic  valid;
	logic  ready;
	byte_t data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface afr_res_if;
	import afr_pkg::*;
	logic  valid;
	logic  ready;
	byte_t payload_byte;
	logic  is_payload;
	logic  frame_last;
	logic  crc_good;
	byte_t frame_length;

	modport source (output valid, output payload_byte, output is_payload, output frame_last,
		output crc_good, output frame_length, input ready);
	modport sink (input valid, input payload_byte, input is_payload, input frame_last,
		input crc_good, input frame_length, output ready);
endinterface

// ----- hw/rtl/addressed_frame_receiver_top.sv -----
`timescale 1ns / 1ps
// Addressed frame receiver: header hunt, payload pass-through and CRC-16 check.
//
//  channel  | dir | beat contents
//  ---------+-----+------------------------------------------------------------
//  rx       | in  | data_byte: one received byte
//  res      | out | payload_byte, is_payload, frame_last, crc_good, frame_length
//  apb      | in  | local_address at byte address 0 (write and read)
//
// One byte is taken per cycle while rx.ready is high. Header check and CRC update run in
// the same cycle as the accept, and the result is registered before it shows on res.
// A result register plus one skid register sit on res; rx.ready drops only while the
// skid register holds a beat, so a stall on res reaches rx through the skid register.
// Reset clears the header window, mode, count and local_address and sets the CRC to CRC_INIT; no clearing pass.
module addressed_frame_receiver_top (
	input  logic                                clk,
	input  logic                                arst_n,
	afr_rx_if.sink                              rx,
	afr_res_if.source                           res,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [afr_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [afr_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [afr_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                pready
);
	import afr_pkg::*;

	logic [ADDR_BITS-1:0] addr_q;
	byte_t                win_q [HDR_LEN];
	logic                 in_payload_q;
	logic [CRC_BITS-1:0]  crc_q;
	byte_t                remain_q;

	result_t out_s1;
	logic    out_valid_s1;
	result_t skid_q;
	logic    skid_valid_q;

	byte_t               win_next [HDR_LEN];
	byte_t               sum;
	logic                hit;
	logic                last;
	logic [CRC_BITS-1:0] crc_next;
	logic [CRC_BITS-1:0] hdr_crc;
	logic                accept;
	logic                push;
	logic                pop;
	result_t             res_new;

	// Configuration port.
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == REG_LOCAL_ADDRESS) begin
			prdata = {{(APB_DATA_BITS-ADDR_BITS){1'b0}}, addr_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr == REG_LOCAL_ADDRESS) begin
			addr_q <= pwdata[ADDR_BITS-1:0];
		end
	end

	// Header window as it stands after shifting in the current byte.
	always_comb begin
		for (int i = 0; i < HDR_LEN - 1; i++) begin
			win_next[i] = win_q[i+1];
		end
		win_next[HDR_LEN-1] = rx.data_byte;
		sum = '0;
		for (int i = 0; i < SUM_LEN; i++) begin
			sum = sum + win_next[i];
		end
		hit = (win_next[0] == addr_q[ADDR_BITS-1 -: BYTE_BITS])
			&& (win_next[1] == addr_q[BYTE_BITS-1:0])
			&& (sum == win_next[SUM_LEN]);
	end

	assign hdr_crc  = {win_q[2], win_q[3]};
	assign crc_next = crc_byte(crc_q, rx.data_byte);
	assign last     = (remain_q <= 8'd1);

	assign rx.ready = !skid_valid_q;
	assign accept   = rx.valid && rx.ready;

	always_comb begin
		res_new = '0;
		push    = 1'b0;
		if (in_payload_q) begin
			push                 = accept;
			res_new.payload_byte = rx.data_byte;
			res_new.is_payload   = 1'b1;
			res_new.frame_last   = last;
			res_new.crc_good     = last && (crc_next == hdr_crc);
			res_new.frame_length = win_q[4];
		end else begin
			// A zero-length header completes its frame at once.
			push                 = accept && hit && (win_next[4] == '0);
			res_new.frame_last   = 1'b1;
			res_new.crc_good     = ({win_next[2], win_next[3]} == CRC_INIT);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HDR_LEN; i++) begin
				win_q[i] <= '0;
			end
			in_payload_q <= 1'b0;
			crc_q        <= CRC_INIT;
			remain_q     <= '0;
		end else if (accept) begin
			if (in_payload_q) begin
				crc_q    <= crc_next;
				remain_q <= last ? '0 : remain_q - 8'd1;
				if (last) begin
					in_payload_q <= 1'b0;
				end
			end else begin
				win_q <= win_next;
				if (hit && win_next[4] != '0) begin
					in_payload_q <= 1'b1;
					remain_q     <= win_next[4];
					crc_q        <= CRC_INIT;
				end
			end
		end
	end

	// Result register with a skid register behind it.
	assign pop = out_valid_s1 && res.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_s1 || pop) begin
			if (skid_valid_q) begin
				out_valid_s1 <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_s1 <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_s1 || pop) begin
			out_s1 <= skid_valid_q ? skid_q : res_new;
		end
		if (push && out_valid_s1 && !pop) begin
			skid_q <= res_new;
		end
	end

	assign res.valid        = out_valid_s1;
	assign res.payload_byte = out_s1.payload_byte;
	assign res.is_payload   = out_s1.is_payload;
	assign res.frame_last   = out_s1.frame_last;
	assign res.crc_good     = out_s1.crc_good;
	assign res.frame_length = out_s1.frame_length;

endmodule

// ----- hw/rtl/afr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the addressed frame receiver, bound to the top level.
module afr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          res_valid,
	input logic                          res_ready,
	input logic [afr_pkg::BYTE_BITS-1:0] payload_byte,
	input logic                          is_payload,
	input logic                          frame_last,
	input logic                          crc_good,
	input logic [afr_pkg::BYTE_BITS-1:0] frame_length,
	input logic                          pready
);
	import afr_pkg::*;

	// A CRC verdict only comes with the end of a frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && crc_good |-> frame_last)
		else $error("crc_good without frame_last");

	// An empty frame reports a single closing beat with zero byte and length.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !is_payload |-> frame_last && payload_byte == '0 && frame_length == '0)
		else $error("malformed zero-length frame beat");

	// A payload beat never reports a zero length.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && is_payload |-> frame_length != '0)
		else $error("payload beat with zero frame length");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(payload_byte)
			&& $stable(frame_last) && $stable(crc_good))
		else $error("result beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready dropped");

endmodule

bind addressed_frame_receiver_top afr_checker u_afr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.payload_byte (res.payload_byte),
	.is_payload   (res.is_payload),
	.frame_last   (res.frame_last),
	.crc_good     (res.crc_good),
	.frame_length (res.frame_length),
	.pready       (pready)
);

// ----- sim/addressed_frame_receiver_top_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the addressed frame receiver: header hunt, payload and CRC verdict.
module addressed_frame_receiver_top_test;
	import afr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_COUNT  = 6;
	localparam int PHASE_BYTES  = 320;
	localparam int CRC_HI_POS   = 2;
	localparam int CRC_LO_POS   = 3;
	localparam int LEN_POS      = 4;

	typedef enum int {FK_GOOD, FK_BAD_CRC, FK_BAD_SUM, FK_WRONG_ADDR} frame_kind_e;
	typedef enum int {RS_OPEN, RS_SPARSE, RS_PERIODIC, RS_HEAVY} ready_style_e;

	logic                     clk;
	logic                     arst_n;
	logic                     psel;
	logic                     penable;
	logic                     pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic                     pready;

	afr_rx_if  rx_ch ();
	afr_res_if res_ch ();

	addressed_frame_receiver_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Mirror of the receiver state, advanced on every accepted byte.
	byte_t       hdr_win [HDR_LEN];
	logic        in_frame;
	logic [15:0] run_crc;
	byte_t       left_count;
	logic [15:0] match_addr;

	result_t expected_results [$];
	byte_t   rx_bytes_pending [$];
	result_t want;

	int  cycle_count;
	int  error_count;
	int  bytes_accepted;
	int  results_checked;
	int  frames_closed;
	int  good_crc_frames;
	int  addr_writes;
	bit  rx_fire;

	int           burst_left;
	int           gap_left;
	ready_style_e ready_style;
	int           style_left;
	int           period_tick;

	function automatic logic [15:0] crc16_update(logic [15:0] acc, byte_t b);
		logic [15:0] c;
		c = acc;
		// Feeding the byte in LSB first, one bit per shift.
		for (int k = 0; k < BYTE_BITS; k++) begin
			c = (c[0] ^ b[k]) ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic void track_rx_byte(byte_t b);
		byte_t       sum;
		logic [15:0] hcrc;
		logic        last;
		result_t     r;
		r = '0;
		if (!in_frame) begin
			for (int i = 0; i < HDR_LEN - 1; i++) begin
				hdr_win[i] = hdr_win[i+1];
			end
			hdr_win[HDR_LEN-1] = b;
			sum = '0;
			for (int i = 0; i < SUM_LEN; i++) begin
				sum += hdr_win[i];
			end
			hcrc = {hdr_win[CRC_HI_POS], hdr_win[CRC_LO_POS]};
			if ({hdr_win[0], hdr_win[1]} == match_addr && sum == hdr_win[SUM_LEN]) begin
				if (hdr_win[LEN_POS] == 0) begin
					r.frame_last = 1'b1;
					r.crc_good   = (hcrc == CRC_INIT);
					expected_results.push_back(r);
				end else begin
					in_frame   = 1'b1;
					left_count = hdr_win[LEN_POS];
					run_crc    = CRC_INIT;
				end
			end
		end else begin
			hcrc       = {hdr_win[CRC_HI_POS], hdr_win[CRC_LO_POS]};
			last       = (left_count <= 1);
			run_crc    = crc16_update(run_crc, b);
			left_count = last ? 8'd0 : left_count - 8'd1;
			r.payload_byte = b;
			r.is_payload   = 1'b1;
			r.frame_last   = last;
			r.crc_good     = last && (run_crc == hcrc);
			r.frame_length = hdr_win[LEN_POS];
			expected_results.push_back(r);
			if (last) begin
				in_frame = 1'b0;
			end
		end
	endfunction

	function automatic void check_field(string field, logic [7:0] expd, logic [7:0] got);
		if (expd !== got) begin
			$display("%0t: %s mismatch: expected 0x%02h, actual 0x%02h", $time, field, expd, got);
			error_count++;
		end
	endfunction

	function automatic void push_header(byte_t b0, byte_t b1, byte_t b2, byte_t b3, byte_t b4,
		bit bad_sum);
		byte_t sum;
		sum = b0 + b1 + b2 + b3 + b4;
		if (bad_sum) begin
			sum ^= 8'(1) << $urandom_range(0, 7);
		end
		rx_bytes_pending.push_back(b0);
		rx_bytes_pending.push_back(b1);
		rx_bytes_pending.push_back(b2);
		rx_bytes_pending.push_back(b3);
		rx_bytes_pending.push_back(b4);
		rx_bytes_pending.push_back(sum);
	endfunction

	// Queues one frame; a negative fill gives random payload bytes.
	function automatic int queue_frame(logic [15:0] addr, int len, frame_kind_e kind, int fill);
		byte_t       body [$];
		byte_t       a_hi;
		byte_t       a_lo;
		logic [15:0] c;
		c    = CRC_INIT;
		a_hi = addr[15:8];
		a_lo = addr[7:0];
		for (int i = 0; i < len; i++) begin
			body.push_back((fill < 0) ? byte_t'($urandom_range(0, 255)) : byte_t'(fill));
			c = crc16_update(c, body[i]);
		end
		if (kind == FK_BAD_CRC) begin
			c ^= 16'(1) << $urandom_range(0, 15);
		end
		if (kind == FK_WRONG_ADDR) begin
			if ($urandom_range(0, 1) == 1) begin
				a_hi ^= 8'(1) << $urandom_range(0, 7);
			end else begin
				a_lo ^= 8'(1) << $urandom_range(0, 7);
			end
		end
		push_header(a_hi, a_lo, c[15:8], c[7:0], byte_t'(len), kind == FK_BAD_SUM);
		foreach (body[i]) begin
			rx_bytes_pending.push_back(body[i]);
		end
		return HDR_LEN + len;
	endfunction

	// Checked at the rising edge, where the sender's falling-edge updates have settled.
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (rx_bytes_pending.size() != 0 || rx_ch.valid || expected_results.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_local_address(logic [15:0] addr);
		logic [APB_DATA_BITS-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_LOCAL_ADDRESS;
		pwdata  <= APB_DATA_BITS'(addr);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		psel    <= 1'b1;
		paddr   <= REG_LOCAL_ADDRESS;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (rd[15:0] !== addr) begin
			$display("%0t: local_address readback mismatch: expected 0x%04h, actual 0x%04h",
				$time, addr, rd[15:0]);
			error_count++;
		end
		match_addr = addr;
		addr_writes++;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Sender: bursts of beats separated by random gaps.
	always @(negedge clk) begin
		if (arst_n && (!rx_ch.valid || rx_fire)) begin
			if (gap_left != 0) begin
				gap_left--;
				rx_ch.valid <= 1'b0;
			end else if (rx_bytes_pending.size() != 0) begin
				rx_ch.valid     <= 1'b1;
				rx_ch.data_byte <= rx_bytes_pending.pop_front();
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				rx_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: a randomly picked stall style drives res.ready until its run ends.
	always @(negedge clk) begin
		if (style_left == 0) begin
			ready_style = ready_style_e'($urandom_range(0, 3));
			style_left  = $urandom_range(50, 300);
		end else begin
			style_left--;
		end
		period_tick = (period_tick + 1) % 16;
		case (ready_style)
			RS_OPEN: begin
				res_ch.ready <= 1'b1;
			end
			RS_SPARSE: begin
				res_ch.ready <= ($urandom_range(0, 3) != 0);
			end
			RS_PERIODIC: begin
				res_ch.ready <= (period_tick >= 10);
			end
			default: begin
				res_ch.ready <= ($urandom_range(0, 1) == 1);
			end
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run stopped at the cycle limit", $time);
			$display("tb: failure");
			$finish;
		end
		rx_fire = arst_n && rx_ch.valid && rx_ch.ready;
		if (rx_fire) begin
			track_rx_byte(rx_ch.data_byte);
			bytes_accepted++;
		end
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, actual byte 0x%02h last %b",
					$time, res_ch.payload_byte, res_ch.frame_last);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("payload_byte", want.payload_byte, res_ch.payload_byte);
				check_field("is_payload", 8'(want.is_payload), 8'(res_ch.is_payload));
				check_field("frame_last", 8'(want.frame_last), 8'(res_ch.frame_last));
				check_field("crc_good", 8'(want.crc_good), 8'(res_ch.crc_good));
				check_field("frame_length", want.frame_length, res_ch.frame_length);
				results_checked++;
				if (want.frame_last) begin
					frames_closed++;
				end
				if (want.crc_good) begin
					good_crc_frames++;
				end
			end
		end
	end

	initial begin
		logic [15:0] addr;
		byte_t       hi;
		byte_t       lo;
		byte_t       s1;
		int          phase_bytes;
		int          pick;
		int          len;

		arst_n          = 1'b0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		rx_ch.valid     = 1'b0;
		rx_ch.data_byte = '0;
		res_ch.ready    = 1'b0;
		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_win[i] = '0;
		end
		in_frame    = 1'b0;
		run_crc     = CRC_INIT;
		left_count  = '0;
		match_addr  = '0;
		burst_left  = 1;
		gap_left    = 0;
		ready_style = RS_OPEN;
		style_left  = 0;
		period_tick = 0;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset window is all zeros and the address is zero, so a single zero byte
		// completes a zero-length header whose CRC field is 0x0000.
		rx_bytes_pending.push_back(8'h00);
		void'(queue_frame(16'h0000, 0, FK_GOOD, -1));
		void'(queue_frame(16'h0000, 1, FK_GOOD, 8'hFF));
		wait_drained();

		// A header whose CRC field equals the address lets the kept window match again
		// two bytes after the frame ends.
		addr = 16'h5AC3;
		set_local_address(addr);
		hi = addr[15:8];
		lo = addr[7:0];
		s1 = hi + lo + hi + lo + 8'h01;
		push_header(hi, lo, hi, lo, 8'h01, 1'b0);
		rx_bytes_pending.push_back(8'h00);
		rx_bytes_pending.push_back(8'h00);
		rx_bytes_pending.push_back(hi + lo + 8'h01 + s1);
		wait_drained();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: addr = 16'hFFFF;
				1: addr = 16'h0000;
				default: addr = 16'($urandom_range(0, 65535));
			endcase
			set_local_address(addr);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				pick = $urandom_range(0, 99);
				len  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(7, 40);
				if ($urandom_range(0, 59) == 0) begin
					len = 255;
				end
				if (pick < 60) begin
					phase_bytes += queue_frame(addr, len, FK_GOOD, -1);
				end else if (pick < 72) begin
					phase_bytes += queue_frame(addr, len, FK_BAD_CRC, -1);
				end else if (pick < 80) begin
					phase_bytes += queue_frame(addr, len, FK_BAD_SUM, -1);
				end else if (pick < 87) begin
					phase_bytes += queue_frame(addr, len, FK_WRONG_ADDR, -1);
				end else begin
					// Line noise between frames.
					repeat ($urandom_range(1, 8)) begin
						rx_bytes_pending.push_back(byte_t'($urandom_range(0, 255)));
						phase_bytes++;
					end
				end
			end
			wait_drained();
		end

		$display("Sent %0d bytes under %0d address settings; checked %0d result beats.",
			bytes_accepted, addr_writes, results_checked);
		$display("Closed %0d frames, %0d of them with a matching CRC; %0d errors.",
			frames_closed, good_crc_frames, error_count);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
